@@ hw/rtl/affine2d_matrix_inverse_macros.svh @@
// assertion macros for the affine inverse block
`ifndef AFFINE2D_MATRIX_INVERSE_MACROS_SVH
`define AFFINE2D_MATRIX_INVERSE_MACROS_SVH
// property must hold on every clock edge outside reset
`define AFI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition implies consequence in the same cycle
`define AFI_IMPLY(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);
`endif

@@ hw/rtl/afi_pkg.sv @@
// ----------------------------------------------------------------------------
// afi_pkg
// shared constants for the affine 2x3 inverse block
// ----------------------------------------------------------------------------
package afi_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int FIFO_DEPTH    = 4;
endpackage

@@ hw/rtl/afi_div_stage.sv @@
// ----------------------------------------------------------------------------
// afi_div_stage
// one restoring step of an unsigned pipelined divider: one quotient bit
// ----------------------------------------------------------------------------
module afi_div_stage #(
	parameter int DB = 64
) (
	input  logic [DB-1:0] rem_in,
	input  logic [DB-1:0] den,
	input  logic          num_bit,
	output logic [DB-1:0] rem_out,
	output logic          q_bit
);
	logic [DB:0] trial;
	// shift in the next dividend bit and try the subtract
	always_comb begin
		trial   = {rem_in, num_bit} - {1'b0, den};
		q_bit   = !trial[DB];
		rem_out = q_bit ? trial[DB-1:0] : {rem_in[DB-2:0], num_bit};
	end
endmodule

@@ hw/rtl/afi_front.sv @@
// ----------------------------------------------------------------------------
// afi_front
// accepts a transform, forms the floored determinant and queues the item
// ----------------------------------------------------------------------------
module afi_front
	import afi_pkg::*;
#(
	parameter int W = WORD_BITS_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [6*W-1:0] in_data,
	output logic           q_valid,
	input  logic           q_ready,
	output logic [6*W-1:0] q_data,
	output logic [2*W-F:0] q_det
);
	localparam int PB = 2*W;
	localparam int DW = 2*W - F + 1;
	localparam int AW = $clog2(FIFO_DEPTH);

	logic signed [W-1:0]  a11, a12, a21, a22;
	logic signed [PB-1:0] p1_s1, p2_s1;
	logic [6*W-1:0]       d_s1, d_s2;
	logic                 v_s1, v_s2;
	logic signed [PB:0]   diff;
	logic signed [DW-1:0] det_s2;
	logic                 adv;

	assign a11 = in_data[W-1:0];
	assign a12 = in_data[2*W-1:W];
	assign a21 = in_data[3*W-1:2*W];
	assign a22 = in_data[4*W-1:3*W];

	// two stage pipe into the queue; stall while queue full and stage two holds an item
	logic [AW:0] cnt_q;
	logic        full;
	assign full     = (cnt_q == (AW+1)'(FIFO_DEPTH));
	assign adv      = !(v_s2 && full) ;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// products then difference with floor shift
	assign diff = (p1_s1 - p2_s1);
	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s1  <= PB'(a11) * PB'(a22);
			p2_s1  <= PB'(a12) * PB'(a21);
			d_s1   <= in_data;
			det_s2 <= DW'(diff >>> F);
			d_s2   <= d_s1;
		end
	end

	// item queue
	logic [6*W+DW-1:0] mem_q [FIFO_DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic              push, pop;
	assign push    = v_s2 && adv;
	assign pop     = q_valid && q_ready;
	assign q_valid = (cnt_q != '0);
	assign {q_det, q_data} = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= {det_s2, d_s2};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

@@ hw/rtl/afi_back.sv @@
// ----------------------------------------------------------------------------
// afi_back
// pipelined divides of the adjugate, inverse translation, saturation
// ----------------------------------------------------------------------------
module afi_back
	import afi_pkg::*;
#(
	parameter int W = WORD_BITS_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  logic [6*W-1:0] q_data,
	input  logic [2*W-F:0] q_det,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [6*W+1:0] out_data
);
	`include "affine2d_matrix_inverse_macros.svh"
	localparam int DW = 2*W - F + 1;   // determinant width, signed
	localparam int NB = W + F + 1;     // magnitude of scaled numerator
	localparam int RB = DW;            // remainder width
	localparam int L  = NB + 3;        // index of the last valid bit
	localparam int PB = 2*W + 2;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	// pipe moves when the output register can take data
	logic adv;
	logic [L:0] v_q;
	assign adv       = !out_valid || out_ready;
	assign q_ready   = adv;
	assign out_valid = v_q[L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[L-1:0], q_valid};
	end

	// stage 0: magnitudes and signs
	logic signed [W-1:0] ent [4];
	assign ent[0] = q_data[4*W-1:3*W];
	assign ent[1] = q_data[2*W-1:W];
	assign ent[2] = q_data[3*W-1:2*W];
	assign ent[3] = q_data[W-1:0];

	logic [NB-1:0]       num_s0 [4];
	logic [3:0]          neg_s0;
	logic [RB-1:0]       den_s0;
	logic                sing_s0;
	logic [2*W-1:0]      sh_s0;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				logic signed [W:0] n;
				n = (i == 1 || i == 2) ? -(W+1)'(ent[i]) : (W+1)'(ent[i]);
				neg_s0[i] <= n[W] ^ q_det[DW-1];
				num_s0[i] <= NB'(n[W] ? -n : n) << F;
			end
			den_s0  <= q_det[DW-1] ? -q_det : q_det;
			sing_s0 <= (q_det == '0);
			sh_s0   <= q_data[6*W-1:4*W];
		end
	end

	// divider pipe: NB steps, four lanes
	logic [NB-1:0] n_p [NB+1][4];
	logic [NB-1:0] qt_p [NB+1][4];
	logic [RB-1:0] r_p [NB+1][4];
	logic [RB-1:0] d_p [NB+1];
	logic [3:0]    ng_p [NB+1];
	logic          sg_p [NB+1];
	logic [2*W-1:0] s_p [NB+1];
	always_comb begin
		d_p[0] = den_s0; ng_p[0] = neg_s0; sg_p[0] = sing_s0; s_p[0] = sh_s0;
		for (int i = 0; i < 4; i++) begin
			n_p[0][i] = num_s0[i]; r_p[0][i] = '0; qt_p[0][i] = '0;
		end
	end
	for (genvar k = 0; k < NB; k++) begin : g_div
		logic [RB-1:0] ro [4];
		logic          qb [4];
		for (genvar i = 0; i < 4; i++) begin : g_lane
			afi_div_stage #(.DB(RB)) u_st (
				.rem_in(r_p[k][i]), .den(d_p[k]), .num_bit(n_p[k][i][NB-1]),
				.rem_out(ro[i]), .q_bit(qb[i])
			);
			always_ff @(posedge clk) begin
				if (adv) begin
					r_p[k+1][i]  <= ro[i];
					n_p[k+1][i]  <= n_p[k][i] << 1;
					qt_p[k+1][i] <= {qt_p[k][i][NB-2:0], qb[i]};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				d_p[k+1] <= d_p[k]; ng_p[k+1] <= ng_p[k];
				sg_p[k+1] <= sg_p[k]; s_p[k+1] <= s_p[k];
			end
		end
	end

	// signed quotient then saturate
	logic signed [W-1:0] inv_s1 [4];
	logic [3:0]          ov_s1;
	logic                sg_s1;
	logic [2*W-1:0]      sh_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				logic signed [NB:0] sq;
				sq = ng_p[NB][i] ? -(NB+1)'(qt_p[NB][i]) : (NB+1)'(qt_p[NB][i]);
				if (sq > (NB+1)'(WMAX)) begin
					inv_s1[i] <= WMAX; ov_s1[i] <= 1'b1;
				end else if (sq < (NB+1)'(WMIN)) begin
					inv_s1[i] <= WMIN; ov_s1[i] <= 1'b1;
				end else begin
					inv_s1[i] <= W'(sq); ov_s1[i] <= 1'b0;
				end
			end
			sg_s1 <= sg_p[NB];
			sh_s1 <= s_p[NB];
		end
	end

	// translation products
	logic signed [2*W-1:0] pr_s2 [4];
	logic signed [W-1:0]   inv_s2 [4];
	logic [3:0]            ov_s2;
	logic                  sg_s2;
	logic signed [W-1:0]   sx, sy;
	assign sx = sh_s1[W-1:0];
	assign sy = sh_s1[2*W-1:W];
	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s2[0] <= (2*W)'(inv_s1[0]) * (2*W)'(sx);
			pr_s2[1] <= (2*W)'(inv_s1[1]) * (2*W)'(sy);
			pr_s2[2] <= (2*W)'(inv_s1[2]) * (2*W)'(sx);
			pr_s2[3] <= (2*W)'(inv_s1[3]) * (2*W)'(sy);
			inv_s2 <= inv_s1; ov_s2 <= ov_s1; sg_s2 <= sg_s1;
		end
	end

	// negated sum, floor, saturate, output register
	logic signed [PB-1:0] t0, t1, f0, f1;
	logic signed [W-1:0]  x0, x1;
	logic                 o0, o1;
	always_comb begin
		t0 = -PB'(pr_s2[0]) - PB'(pr_s2[1]);
		t1 = -PB'(pr_s2[2]) - PB'(pr_s2[3]);
		f0 = t0 >>> F;
		f1 = t1 >>> F;
		o0 = (f0 > PB'(WMAX)) || (f0 < PB'(WMIN));
		o1 = (f1 > PB'(WMAX)) || (f1 < PB'(WMIN));
		x0 = o0 ? (f0[PB-1] ? WMIN : WMAX) : W'(f0);
		x1 = o1 ? (f1[PB-1] ? WMIN : WMAX) : W'(f1);
	end
	logic [6*W+1:0] res_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (sg_s2) res_q <= {1'b0, 1'b1, {(6*W){1'b0}}};
			else res_q <= {(|ov_s2) | o0 | o1, 1'b0, x1, x0,
				inv_s2[3], inv_s2[2], inv_s2[1], inv_s2[0]};
		end
	end
	assign out_data = res_q;

	`AFI_IMPLY(a_sing_zero, out_valid && out_data[6*W], out_data[6*W-1:0] == '0 && !out_data[6*W+1], "singular result not cleared")
	`AFI_IMPLY(a_hold, out_valid && !out_ready, ##1 out_valid && $stable(out_data), "stalled result changed")
	`AFI_ASSERT(a_ready, q_ready == (!out_valid || out_ready), "back ready mismatch")
endmodule

@@ hw/rtl/affine2d_matrix_inverse.sv @@
// ----------------------------------------------------------------------------
// affine2d_matrix_inverse
// inverts a 2x3 affine transform in signed fixed point
// ----------------------------------------------------------------------------
// usage:
//  s_axis carries one transform per transaction, m_axis one inverse.
//  tdata in : a11, a12, a21, a22, shift_x, shift_y from bit 0 up.
//  tdata out: inv11..inv22, inv_shift_x, inv_shift_y; tuser: singular, overflow.
//  a new transform is taken every cycle while the output is taken.
//  an input transaction passes two front stages and a queue write, then the
//  back stages (the restoring divider pipe, one quotient bit per stage, four
//  lanes sharing the determinant) before m_axis_tvalid rises.
//  the front computes the determinant in two stages and fills a four
//  entry queue; the back pulls from it whenever its output register frees.
//  when the receiver stalls the back pipe freezes and the queue fills, then
//  s_axis_tready drops. reset empties the pipes and the queue.
// ----------------------------------------------------------------------------
module affine2d_matrix_inverse
	import afi_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [6*WORD_BITS-1:0] s_axis_tdata,  // a11,a12,a21,a22,shift_x,shift_y
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [6*WORD_BITS-1:0] m_axis_tdata,  // inv11,inv12,inv21,inv22,inv_shift_x,inv_shift_y
	output logic [1:0]             m_axis_tuser   // singular, overflow
);
	localparam int DW = 2*WORD_BITS - FRAC_BITS + 1;
	logic                   q_valid, q_ready;
	logic [6*WORD_BITS-1:0] q_data;
	logic [DW-1:0]          q_det;
	logic [6*WORD_BITS+1:0] res;

	// front: determinant and queue
	afi_front #(.W(WORD_BITS), .F(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .q_valid, .q_ready, .q_data, .q_det
	);

	// back: divides and translation
	afi_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data, .q_det,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = res[6*WORD_BITS-1:0];
	assign m_axis_tuser = res[6*WORD_BITS+1:6*WORD_BITS];
endmodule
